// ===== hdl/fractional_delay_line_linear_interp_core_macros.svh =====
// Assertion macros for the fractional delay line core.
// No dependencies; taken in by the files that carry assertions.
`ifndef FRACTIONAL_DELAY_LINE_LINEAR_INTERP_CORE_MACROS_SVH
`define FRACTIONAL_DELAY_LINE_LINEAR_INTERP_CORE_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define FDL_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fdl assertion failed");

// antecedent implies consequent in the next cycle
`define FDL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fdl assertion failed");

// expression always holds
`define FDL_ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("fdl assertion failed");

`else

`define FDL_ASSERT_SAME(label, clk, rst, ante, cons)
`define FDL_ASSERT_NEXT(label, clk, rst, ante, cons)
`define FDL_ASSERT_ALWAYS(label, clk, rst, expr)

`endif

`endif

// ===== hdl/fdl_pkg.sv =====
// Shared types and constants for the fractional delay line core.
// No dependencies.
package fdl_pkg;

  localparam int DELAY_W     = 12;
  localparam int FRAC_W      = 16;
  localparam int GAIN_W      = 18;
  localparam int CFG_W       = 18;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_DELAY_WHOLE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_FRACTION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN           = 2'd2;

  localparam logic [GAIN_W-1:0]  GAIN_RESET = 18'h10000;
  localparam logic [FRAC_W:0]    Q16_ONE    = 17'h10000;
  localparam int                 Q_SHIFT    = 16;
  localparam int                 ROUND_HALF = 32768;

  typedef struct packed {
    logic load;
    logic write;
    logic rd_near;
    logic rd_far;
    logic mul_near;
    logic mul_far;
    logic finish;
  } fdl_cmd_t;

endpackage

// ===== hdl/fdl_datapath.sv =====
// Datapath: config registers, gain multiply, circular store, blend and output register.
// Depends on fdl_pkg; driven by commands from fdl_ctrl.
module fdl_datapath import fdl_pkg::*; #(
  parameter int BUFFER_DEPTH = 4096,
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  fdl_cmd_t                      cmd,
  input  logic                          cfg_write,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]              cfg_data,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out
);

  localparam int AW  = $clog2(BUFFER_DEPTH);
  localparam int XW  = ((AW > DELAY_W) ? AW : DELAY_W) + 2;
  localparam int SW  = SAMPLE_WIDTH;
  localparam int PGW = SW + GAIN_W;
  localparam int RGW = PGW + 1;
  localparam int PBW = SW + FRAC_W + 2;
  localparam int RBW = PBW + 2;

  localparam logic [XW-1:0] DEPTH_X = XW'(BUFFER_DEPTH);
  localparam logic [XW-1:0] DMAX_X  = XW'(BUFFER_DEPTH - 2);
  localparam logic [AW-1:0] LAST_A  = AW'(BUFFER_DEPTH - 1);
  localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

  logic [DELAY_W-1:0]      delay_whole;
  logic [FRAC_W-1:0]       delay_fraction;
  logic signed [GAIN_W-1:0] gain;

  logic [AW-1:0] wptr;
  logic          full;
  logic [AW-1:0] near_addr;
  logic [AW-1:0] far_addr;
  logic          near_ok;
  logic          far_ok;
  logic [FRAC_W:0] wnear;

  logic signed [PGW-1:0] prod_g;
  logic signed [PBW-1:0] prod_near;
  logic signed [PBW-1:0] prod_far;

  logic signed [SW-1:0] mem [BUFFER_DEPTH];
  logic signed [SW-1:0] rdata;
  logic                 rd_ok;
  logic [AW-1:0]        mem_addr;

  logic [XW-1:0] d_x, d_c, w_x, near_x;
  logic [AW-1:0] far_c;
  logic signed [RGW-1:0] rg;
  logic signed [RGW-Q_SHIFT-1:0] rg_s;
  logic signed [SW-1:0] wval;
  logic signed [SW-1:0] near_v;
  logic signed [PBW:0]  bsum;
  logic signed [RBW-1:0] rb;
  logic signed [RBW-Q_SHIFT-1:0] rb_s;
  logic signed [SW-1:0] yval;

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_whole    <= '0;
      delay_fraction <= '0;
      gain           <= GAIN_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DELAY_WHOLE:    delay_whole    <= cfg_data[DELAY_W-1:0];
        REG_DELAY_FRACTION: delay_fraction <= cfg_data[FRAC_W-1:0];
        REG_GAIN:           gain           <= cfg_data[GAIN_W-1:0];
        default:            ;
      endcase
    end
  end

  // read addresses behind the write pointer, delay clamped to depth - 2
  always_comb begin
    d_x    = XW'(delay_whole);
    d_c    = (d_x > DMAX_X) ? DMAX_X : d_x;
    w_x    = XW'(wptr);
    near_x = (w_x >= d_c) ? (w_x - d_c) : (w_x + DEPTH_X - d_c);
    far_c  = (near_addr == '0) ? LAST_A : (near_addr - 1'b1);
  end

  // round half up and saturate the gained sample
  always_comb begin
    rg   = RGW'(prod_g) + RGW'(ROUND_HALF);
    rg_s = rg[RGW-1:Q_SHIFT];
    if ((&rg_s[RGW-Q_SHIFT-1:SW-1]) || !(|rg_s[RGW-Q_SHIFT-1:SW-1])) begin
      wval = rg_s[SW-1:0];
    end else begin
      wval = rg_s[RGW-Q_SHIFT-1] ? S_MIN : S_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      full <= 1'b0;
    end else if (cmd.write) begin
      wptr <= (wptr == LAST_A) ? '0 : (wptr + 1'b1);
      if (wptr == LAST_A) begin
        full <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      prod_g    <= sample_in * gain;
      near_addr <= near_x[AW-1:0];
      near_ok   <= full || (near_x[AW-1:0] <= wptr);
      wnear     <= Q16_ONE - {1'b0, delay_fraction};
    end
    if (cmd.write) begin
      far_addr <= far_c;
      far_ok   <= full || (far_c <= wptr);
    end
  end

  // single-port store: one write or one read per cycle
  always_comb begin
    if (cmd.write) begin
      mem_addr = wptr;
    end else if (cmd.rd_near) begin
      mem_addr = near_addr;
    end else begin
      mem_addr = far_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      mem[mem_addr] <= wval;
    end
    rdata <= mem[mem_addr];
    rd_ok <= cmd.rd_near ? near_ok : far_ok;
  end

  // entries not yet written since reset read as zero
  assign near_v = rd_ok ? rdata : '0;

  always_ff @(posedge clk) begin
    if (cmd.mul_near) begin
      prod_near <= near_v * $signed({1'b0, wnear});
    end
    if (cmd.mul_far) begin
      prod_far <= near_v * $signed({2'b00, delay_fraction});
    end
  end

  always_comb begin
    bsum = (PBW+1)'(prod_near) + (PBW+1)'(prod_far);
    rb   = RBW'(bsum) + RBW'(ROUND_HALF);
    rb_s = rb[RBW-1:Q_SHIFT];
    if ((&rb_s[RBW-Q_SHIFT-1:SW-1]) || !(|rb_s[RBW-Q_SHIFT-1:SW-1])) begin
      yval = rb_s[SW-1:0];
    end else begin
      yval = rb_s[RBW-Q_SHIFT-1] ? S_MIN : S_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      sample_out <= yval;
    end
  end

endmodule

// ===== hdl/fdl_ctrl.sv =====
// Controller: sequences write, two reads, two multiplies and the output beat.
// Depends on fdl_pkg and the assertion macro header.
`include "fractional_delay_line_linear_interp_core_macros.svh"

module fdl_ctrl import fdl_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output fdl_cmd_t cmd
);

  typedef enum logic [2:0] {
    IDLE,
    WRITE,
    RD_NEAR,
    RD_FAR,
    MUL_FAR,
    SUM
  } state_t;

  state_t state;
  logic   out_free;

  assign in_stall = (state != IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd          = '0;
    cmd.load     = (state == IDLE) && in_valid;
    cmd.write    = (state == WRITE);
    cmd.rd_near  = (state == RD_NEAR);
    cmd.rd_far   = (state == RD_FAR);
    cmd.mul_near = (state == RD_FAR);
    cmd.mul_far  = (state == MUL_FAR);
    cmd.finish   = (state == SUM) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE:    if (in_valid) state <= WRITE;
        WRITE:   state <= RD_NEAR;
        RD_NEAR: state <= RD_FAR;
        RD_FAR:  state <= MUL_FAR;
        MUL_FAR: state <= SUM;
        SUM: begin
          if (out_free) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  `FDL_ASSERT_NEXT(a_accept_writes, clk, rst, in_valid && !in_stall, cmd.write)
  `FDL_ASSERT_ALWAYS(a_one_mem_op, clk, rst, $onehot0({cmd.write, cmd.rd_near, cmd.rd_far}))
  `FDL_ASSERT_NEXT(a_near_then_far, clk, rst, cmd.rd_near, cmd.rd_far && cmd.mul_near)
  `FDL_ASSERT_NEXT(a_finish_shows, clk, rst, cmd.finish, out_valid)

endmodule

// ===== hdl/fractional_delay_line_linear_interp_core.sv =====
// Fractional delay line with linear interpolation, top level.
// One signed sample in per beat, one interpolated sample out per beat.
// Input channel: in_valid / in_stall with sample_in; output channel:
// out_valid / out_stall with sample_out. Config: cfg_write, cfg_index,
// cfg_data (0 delay_whole, 1 delay_fraction, 2 gain Q1.16); write only while idle.
// Each sample is gained, rounded, saturated and written to a circular store,
// then the entries delay_whole and delay_whole+1 behind it are blended.
// The result is registered in SUM, after the WRITE, RD_NEAR, RD_FAR and MUL_FAR states.
// A new beat is taken only back in IDLE, as the single-port store
// (one write and two reads) and the two blend multiplies run in turn.
// The output register holds a result while out_stall is high; the next
// input is taken meanwhile but its result waits until the register is free.
// Reset: pointer and control cleared, gain 1.0, delay 0; entries not yet
// written since reset read as zero through a fill mark, so no clearing pass.
// Depends on fdl_pkg, fdl_ctrl and fdl_datapath.
module fractional_delay_line_linear_interp_core import fdl_pkg::*; #(
  parameter int BUFFER_DEPTH = 4096,
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out,
  input  logic                           cfg_write,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [CFG_W-1:0]               cfg_data
);

  fdl_cmd_t cmd;

  fdl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  fdl_datapath #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sample_in  (sample_in),
    .sample_out (sample_out)
  );

endmodule
